FILE: rtl/dcbma_pkg.sv
// Package for the DC blocker built from cascaded moving averages.
// Holds register codes, fixed field widths and the controller/datapath interface types.
// No dependencies.
`timescale 1ns / 1ps

package dcbma_pkg;

   // Configuration register indexes and the width of the index field.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RECIP_LENGTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_MODE     = 2'd2;

   // Register field widths and reset values.
   localparam int FILTER_LENGTH_W = 7;
   localparam int RECIP_W         = 18;
   localparam logic [FILTER_LENGTH_W-1:0] FILTER_LENGTH_RESET = 7'd32;
   localparam logic [RECIP_W-1:0]         RECIP_LENGTH_RESET  = 18'd4096;
   localparam int MIN_LENGTH = 2;

   // Arithmetic constants of one averaging stage.
   localparam int SUM_BITS  = 44;
   localparam int FRAC_BITS = 17;

   // Stage and line organisation.
   localparam int NUM_CHANNELS      = 2;
   localparam int NUM_STAGES        = 4;
   localparam int STAGE_W           = 2;
   localparam int LANES_PER_CHANNEL = NUM_STAGES + 1;
   localparam int MATCH_LANE        = NUM_STAGES;
   localparam logic [STAGE_W-1:0] STAGE_SHORT_TAP = 2'd1;
   localparam logic [STAGE_W-1:0] STAGE_LAST      = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic               clr_en;
      logic               start;
      logic               rd_en;
      logic               sum_en;
      logic               mlo_en;
      logic               mhi_en;
      logic               res_en;
      logic               fin_en;
      logic [STAGE_W-1:0] stage;
   } dcbma_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
   } dcbma_sts_type;

endpackage

FILE: rtl/dc_blocker_moving_average_top.sv
// Top level of the complex DC blocker built from cascaded moving averages.
// Joins dcbma_ctrl and dcbma_dp; depends on dcbma_pkg.
//
// Usage:
//   req_* carries one complex input sample per transaction, rsp_* one DC-removed
//   sample per transaction, csr_* writes the filter length, reciprocal length and
//   long mode registers (index 0, 1, 2). Configuration is written while idle.
//   Each sample runs through four averaging stages in turn on one pair of narrow
//   partial-product multipliers per channel; each stage steps through sum, low
//   partial product, high partial product, round and clip in turn. The result is
//   registered in the output register once the last stage is done and the register
//   is free; only then is the next sample taken. After reset the delay line RAM is
//   cleared, one address per cycle, over all MAX_LENGTH - 1 addresses; req_tready
//   stays low meanwhile. A sample may be taken while the previous result waits in
//   the output register; if the receiver stalls, the block holds the finished
//   sample until rsp_tready is seen.
`timescale 1ns / 1ps

module dc_blocker_moving_average_top
   import dcbma_pkg::*;
#(
   parameter int MAX_LENGTH   = 64,
   parameter int SAMPLE_WIDTH = 16,
   parameter int DATA_W       = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,   // sample_i, sample_q, zero pad
   input  logic                   req_tlast,   // last_in
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,   // out_i, out_q, zero pad
   output logic                   rsp_tlast,   // last_out
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [RECIP_W-1:0]     csr_data
);

   dcbma_cmd_type cmd;
   dcbma_sts_type sts;

   dcbma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dcbma_dp #(
      .MAX_LENGTH  (MAX_LENGTH),
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .DATA_W      (DATA_W)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

endmodule

FILE: rtl/dcbma_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module dcbma_ram #(
   parameter int WIDTH = 160,
   parameter int DEPTH = 63
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/dcbma_ctrl.sv
// Controller of the DC blocker: sequences the clearing pass and the stage steps of each sample.
// Depends on dcbma_pkg.
`timescale 1ns / 1ps

module dcbma_ctrl
   import dcbma_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dcbma_sts_type sts,
   output dcbma_cmd_type cmd
);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_READ  = 8'b0000_0100,
      ST_SUM   = 8'b0000_1000,
      ST_MLO   = 8'b0001_0000,
      ST_MHI   = 8'b0010_0000,
      ST_RES   = 8'b0100_0000,
      ST_FINAL = 8'b1000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [STAGE_W-1:0] stage_ff, stage_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      cmd          = '0;
      cmd.stage    = stage_ff;
      req_tready   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               stage_in  = '0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = ST_MLO;
         end
         ST_MLO: begin
            cmd.mlo_en = 1'b1;
            state_in   = ST_MHI;
         end
         ST_MHI: begin
            cmd.mhi_en = 1'b1;
            state_in   = ST_RES;
         end
         ST_RES: begin
            cmd.res_en = 1'b1;
            if (stage_ff == STAGE_LAST) begin
               state_in = ST_FINAL;
            end else begin
               stage_in = stage_ff + STAGE_W'(1);
               state_in = ST_SUM;
            end
         end
         ST_FINAL: begin
            // Finish only once the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.fin_en = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Output valid flag: set on finishing a sample, cleared when the transaction completes.
   always_comb begin
      if (cmd.fin_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         stage_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: rtl/dcbma_dp.sv
// Datapath of the DC blocker: configuration registers, running sums, scaling multipliers
// shared by the stages, delay line RAM and the output register. Depends on dcbma_pkg and dcbma_ram.
`timescale 1ns / 1ps

module dcbma_dp
   import dcbma_pkg::*;
#(
   parameter int MAX_LENGTH   = 64,
   parameter int SAMPLE_WIDTH = 16,
   parameter int DATA_W       = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dcbma_cmd_type          cmd,
   output dcbma_sts_type          sts,
   input  logic [DATA_W-1:0]      req_tdata,
   input  logic                   req_tlast,
   output logic [DATA_W-1:0]      rsp_tdata,
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [RECIP_W-1:0]     csr_data
);

   localparam int SW        = SAMPLE_WIDTH;
   localparam int LINE_LEN  = MAX_LENGTH - 1;
   localparam int PTR_W     = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
   localparam int LEN_CLOG  = $clog2(MAX_LENGTH + 1);
   localparam int LEN_W     = (LEN_CLOG > FILTER_LENGTH_W) ? LEN_CLOG : FILTER_LENGTH_W;
   localparam int NUM_LANES = NUM_CHANNELS * LANES_PER_CHANNEL;
   localparam int WORD_W    = NUM_LANES * SW;
   localparam int LO_W      = SUM_BITS / 2;
   localparam int HI_W      = SUM_BITS - LO_W;
   localparam int PLO_W     = LO_W + RECIP_W;
   localparam int PHI_W     = HI_W + RECIP_W + 1;
   localparam int PROD_W    = SUM_BITS + RECIP_W + 1;
   localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] SAT_HI =
      {{(PROD_W - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
   localparam logic signed [PROD_W-1:0] SAT_LO =
      {{(PROD_W - SW + 1){1'b1}}, {(SW - 1){1'b0}}};

   // Configuration registers.
   logic [FILTER_LENGTH_W-1:0] filter_length_ff;
   logic [RECIP_W-1:0]         recip_ff;
   logic                       long_mode_ff;

   // Control state of the delay lines.
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [PTR_W-1:0] p_ff, p_in;
   logic [PTR_W-1:0] clr_addr_ff, clr_addr_in;

   // Stage state.
   logic signed [SUM_BITS-1:0] sums_ff  [NUM_CHANNELS][NUM_STAGES];
   logic [SW-1:0]              prior_ff [NUM_CHANNELS][NUM_STAGES];

   // Working registers of one sample.
   logic [SW-1:0]              x_ff    [NUM_CHANNELS];
   logic [SW-1:0]              y2_ff   [NUM_CHANNELS];
   logic [SW-1:0]              wbuf_ff [NUM_CHANNELS][NUM_STAGES];
   logic signed [SUM_BITS-1:0] s_ff    [NUM_CHANNELS];
   logic [PLO_W-1:0]           plo_ff  [NUM_CHANNELS];
   logic signed [PHI_W-1:0]    phi_ff  [NUM_CHANNELS];
   logic                       last_ff;
   logic [SW-1:0]              rsp_ff  [NUM_CHANNELS];
   logic                       rsp_last_ff;

   // Combinational values.
   logic [LEN_W-1:0]           len_ext;
   logic [LEN_W-1:0]           len_clamped;
   logic [LEN_W-1:0]           span;
   logic [LEN_W-1:0]           ptr_inc;
   logic [SW-1:0]              old_line [NUM_CHANNELS];
   logic signed [SUM_BITS-1:0] sum_new  [NUM_CHANNELS];
   logic [PLO_W-1:0]           plo      [NUM_CHANNELS];
   logic signed [PHI_W-1:0]    phi      [NUM_CHANNELS];
   logic signed [PROD_W-1:0]   prod     [NUM_CHANNELS];
   logic signed [PROD_W-1:0]   scaled   [NUM_CHANNELS];
   logic [SW-1:0]              y        [NUM_CHANNELS];
   logic signed [SW:0]         diff     [NUM_CHANNELS];
   logic [SW-1:0]              out_sat  [NUM_CHANNELS];
   logic [WORD_W-1:0]          fin_word;
   logic [WORD_W-1:0]          rd_word;
   logic                       ram_we;
   logic [PTR_W-1:0]           ram_waddr;
   logic [WORD_W-1:0]          ram_wdata;

   function automatic logic signed [SUM_BITS-1:0] sext_sum(input logic [SW-1:0] v);
      sext_sum = {{(SUM_BITS - SW){v[SW-1]}}, v};
   endfunction

   function automatic logic signed [SW:0] sext_diff(input logic [SW-1:0] v);
      sext_diff = {v[SW-1], v};
   endfunction

   function automatic logic [SW-1:0] sat_scaled(input logic signed [PROD_W-1:0] v);
      if (v > SAT_HI) begin
         sat_scaled = SAT_HI[SW-1:0];
      end else if (v < SAT_LO) begin
         sat_scaled = SAT_LO[SW-1:0];
      end else begin
         sat_scaled = v[SW-1:0];
      end
   endfunction

   function automatic logic [SW-1:0] sat_diff(input logic signed [SW:0] v);
      if (v[SW] != v[SW-1]) begin
         sat_diff = v[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
      end else begin
         sat_diff = v[SW-1:0];
      end
   endfunction

   // Configuration writes are always accepted.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_length_ff <= FILTER_LENGTH_RESET;
         recip_ff         <= RECIP_LENGTH_RESET;
         long_mode_ff     <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_FILTER_LENGTH: filter_length_ff <= csr_data[FILTER_LENGTH_W-1:0];
            REG_RECIP_LENGTH:  recip_ff         <= csr_data;
            REG_LONG_MODE:     long_mode_ff     <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Length clamp and delay pointer arithmetic.
   always_comb begin
      len_ext = LEN_W'(filter_length_ff);
      if (len_ext < LEN_W'(MIN_LENGTH)) begin
         len_clamped = LEN_W'(MIN_LENGTH);
      end else if (len_ext > LEN_W'(MAX_LENGTH)) begin
         len_clamped = LEN_W'(MAX_LENGTH);
      end else begin
         len_clamped = len_ext;
      end
      span    = len_clamped - LEN_W'(1);
      ptr_inc = LEN_W'(p_ff) + LEN_W'(1);

      p_in = p_ff;
      if (cmd.start) begin
         p_in = (LEN_W'(ptr_ff) >= span) ? '0 : ptr_ff;
      end
      ptr_in = ptr_ff;
      if (cmd.fin_en) begin
         ptr_in = (ptr_inc >= span) ? '0 : ptr_inc[PTR_W-1:0];
      end
   end

   // Clearing pass address counter.
   assign sts.clear_last = (clr_addr_ff == PTR_W'(LINE_LEN - 1));
   always_comb begin
      clr_addr_in = clr_addr_ff;
      if (cmd.clr_en && !sts.clear_last) begin
         clr_addr_in = clr_addr_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         p_ff        <= '0;
         clr_addr_ff <= '0;
      end else begin
         ptr_ff      <= ptr_in;
         p_ff        <= p_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Stage arithmetic for both channels: running sum, two partial products, round and clip.
   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         old_line[c] = rd_word[(c * LANES_PER_CHANNEL + int'(cmd.stage)) * SW +: SW];
         sum_new[c]  = sums_ff[c][cmd.stage] + sext_sum(x_ff[c])
                       - sext_sum(prior_ff[c][cmd.stage]);
         plo[c]      = s_ff[c][LO_W-1:0] * recip_ff;
         phi[c]      = $signed(s_ff[c][SUM_BITS-1:LO_W]) * $signed({1'b0, recip_ff});
         prod[c]     = $signed({phi_ff[c], {LO_W{1'b0}}})
                       + $signed({{(PROD_W - PLO_W){1'b0}}, plo_ff[c]}) + ROUND_BIAS;
         scaled[c]   = prod[c] >>> FRAC_BITS;
         y[c]        = sat_scaled(scaled[c]);
      end
   end

   // Final subtraction: short form uses the second stage, long form the fourth.
   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (long_mode_ff) begin
            diff[c] = sext_diff(rd_word[(c * LANES_PER_CHANNEL + MATCH_LANE) * SW +: SW])
                      - sext_diff(x_ff[c]);
         end else begin
            diff[c] = sext_diff(prior_ff[c][0]) - sext_diff(y2_ff[c]);
         end
         out_sat[c] = sat_diff(diff[c]);
      end
   end

   // Word written back to the delay lines at the end of a sample.
   always_comb begin
      fin_word = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            fin_word[(c * LANES_PER_CHANNEL + k) * SW +: SW] = wbuf_ff[c][k];
         end
         fin_word[(c * LANES_PER_CHANNEL + MATCH_LANE) * SW +: SW] = prior_ff[c][0];
      end
   end

   // Stage state, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            for (int k = 0; k < NUM_STAGES; k++) begin
               sums_ff[c][k]  <= '0;
               prior_ff[c][k] <= '0;
            end
         end
      end else if (cmd.sum_en) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            sums_ff[c][cmd.stage]  <= sum_new[c];
            prior_ff[c][cmd.stage] <= old_line[c];
         end
      end
   end

   // Working and output registers.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff[0] <= req_tdata[SW-1:0];
         x_ff[1] <= req_tdata[2*SW-1:SW];
         last_ff <= req_tlast;
      end
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (cmd.sum_en) begin
            s_ff[c]               <= sum_new[c];
            wbuf_ff[c][cmd.stage] <= x_ff[c];
         end
         if (cmd.mlo_en) begin
            plo_ff[c] <= plo[c];
         end
         if (cmd.mhi_en) begin
            phi_ff[c] <= phi[c];
         end
         if (cmd.res_en) begin
            x_ff[c] <= y[c];
            if (cmd.stage == STAGE_SHORT_TAP) begin
               y2_ff[c] <= y[c];
            end
         end
         if (cmd.fin_en) begin
            rsp_ff[c] <= out_sat[c];
         end
      end
      if (cmd.fin_en) begin
         rsp_last_ff <= last_ff;
      end
   end

   // Delay line RAM port selection: zeros during the clearing pass, write-back otherwise.
   assign ram_we    = cmd.clr_en | cmd.fin_en;
   assign ram_waddr = cmd.clr_en ? clr_addr_ff : p_ff;
   assign ram_wdata = cmd.clr_en ? '0 : fin_word;

   dcbma_ram #(
      .WIDTH(WORD_W),
      .DEPTH(LINE_LEN)
   ) u_lines (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (cmd.rd_en),
      .raddr(p_ff),
      .rdata(rd_word)
   );

   assign rsp_tdata = DATA_W'({rsp_ff[1], rsp_ff[0]});
   assign rsp_tlast = rsp_last_ff;

endmodule

FILE: rtl/dcbma_checker.sv
// Port-level checker for the DC blocker top level, attached by a bind statement.
// Depends on dc_blocker_moving_average_top.
`timescale 1ns / 1ps

module dcbma_checker #(
   parameter int DATA_W = 32
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic              rsp_tlast
);

   // No result is pending in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // A stalled result holds its value.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed or dropped");

   // Samples are worked one at a time: no input transaction in the cycle after another.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while a sample is still at work");

   // A new result never appears in the cycle right after an input transaction.
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result appeared too soon after its input");

endmodule

bind dc_blocker_moving_average_top dcbma_checker #(
   .DATA_W(DATA_W)
) u_dcbma_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);
